// ----- rtl/granular_grain_bank_mixer_core_macros.svh -----
// Assertion macros shared by the grain bank mixer RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef GRANULAR_GRAIN_BANK_MIXER_CORE_MACROS_SVH
`define GRANULAR_GRAIN_BANK_MIXER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define GBM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define GBM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/gbm_pkg.sv -----
// Package for the grain bank mixer: word types, defaults and fixed constants.
// No dependencies; used by the channel interfaces and the core.
`default_nettype none

package gbm_pkg;

    // Default sizing
    localparam int NUM_SLOTS_DEF   = 4;
    localparam int STORE_DEPTH_DEF = 1024;

    // Slot reset values
    localparam logic [11:0] SLOT_RESET_COUNT = 12'd256;
    localparam logic [10:0] SLOT_RESET_LEN   = 11'd256;
    localparam logic [4:0]  SLOT_RESET_STEP  = 5'd1;
    localparam logic [15:0] SLOT_RESET_GAIN  = 16'd32768;

    // Divider: quotient fits in 16 bits since window <= 1.0
    localparam int DIV_STEPS = 16;

    // Output clamp
    localparam int MIX_MAX = 524287;
    localparam int MIX_MIN = -524288;

    // Item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [9:0]         write_address;
        logic signed [15:0] write_sample;
        logic               trigger;
        logic [9:0]         grain_start;
        logic [10:0]        grain_length;
        logic [4:0]         grain_step;
        logic [15:0]        grain_gain;
    } t_in_word;

    typedef struct packed {
        logic signed [19:0] mix_sample;
    } t_out_word;

endpackage

`default_nettype wire

// ----- rtl/gbm_if.sv -----
// Valid/ready channel interfaces for the grain bank mixer.
// Depends on gbm_pkg for the word types.
`default_nettype none

// Input channel: write and tick words
interface gbm_in_if;
    logic              valid;
    logic              ready;
    gbm_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Output channel: mixed samples
interface gbm_out_if;
    logic               valid;
    logic               ready;
    gbm_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/granular_grain_bank_mixer_core.sv -----
// Grain bank mixer core: sample store, grain slot bank, shared multiply/divide.
// Depends on gbm_pkg, gbm_if.sv, gbm_ram and the assertion macro header.
//
//   channel  | dir | handshake     | word
//   ---------+-----+---------------+-----------------------------------------
//   i_in     | in  | valid & ready | kind, store write fields, grain fields
//   o_out    | out | valid & ready | mix_sample, one per tick word
//
// A write word is taken while idle. A tick word walks the slots in turn; each running
// slot passes S_MUL1, S_MUL2, S_DIV and S_ACC, and no new word is taken until the pass
// ends; the 16-step restoring divider in S_DIV is shared by all slots.
// Reset clears the slot bank, the round-robin pointer and the output valid flag;
// the sample store is not cleared. A finished mix waits in the output register
// while the next word is taken; a tick that ends before it is read holds there.
`default_nettype none

`include "granular_grain_bank_mixer_core_macros.svh"

module granular_grain_bank_mixer_core #(
    parameter int NUM_SLOTS   = gbm_pkg::NUM_SLOTS_DEF,
    parameter int STORE_DEPTH = gbm_pkg::STORE_DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    gbm_in_if.sink     i_in,
    gbm_out_if.source  o_out
);

    localparam int AW     = $clog2(STORE_DEPTH);
    localparam int IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SUM_W  = 19 + $clog2(NUM_SLOTS);
    localparam int DCNT_W = $clog2(gbm_pkg::DIV_STEPS);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SLOT = 7'b0000010,
        S_MUL1 = 7'b0000100,
        S_MUL2 = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_ACC  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    // Control state
    t_state r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_next, n_next;
    logic r_ovalid, n_ovalid;

    // Slot bank
    logic [11:0] r_s_cnt   [NUM_SLOTS];
    logic [11:0] n_s_cnt   [NUM_SLOTS];
    logic [9:0]  r_s_start [NUM_SLOTS];
    logic [9:0]  n_s_start [NUM_SLOTS];
    logic [10:0] r_s_len   [NUM_SLOTS];
    logic [10:0] n_s_len   [NUM_SLOTS];
    logic [4:0]  r_s_step  [NUM_SLOTS];
    logic [4:0]  n_s_step  [NUM_SLOTS];
    logic [15:0] r_s_gain  [NUM_SLOTS];
    logic [15:0] n_s_gain  [NUM_SLOTS];

    // Datapath
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic [10:0]       r_len, n_len;
    logic [15:0]       r_gain, n_gain;
    logic [11:0]       r_wn, n_wn;
    logic              r_inrange, n_inrange;
    logic              r_neg, n_neg;
    logic [31:0]       r_mul, n_mul;
    logic [10:0]       r_rem, n_rem;
    logic [15:0]       r_quo, n_quo;
    logic [DCNT_W-1:0] r_dcnt, n_dcnt;
    logic [19:0]       r_omix, n_omix;

    // Shared multiplier operands
    logic [31:0] mul_a;
    logic [15:0] mul_b;
    logic [41:0] mul_p;

    // Misc combinational
    logic           in_acc;
    logic           out_take;
    logic [16:0]    wr_addr_ext;
    logic           wr_en;
    logic [16:0]    rd_addr_ext;
    logic           rd_en;
    logic [15:0]    ram_rdata;
    logic [11:0]    cur_cnt;
    logic [10:0]    cur_len;
    logic [11:0]    c_new;
    logic [12:0]    two_c;
    logic [10:0]    len_diff;
    logic [11:0]    wn_calc;
    logic [15:0]    smp;
    logic [15:0]    smp_mag;
    logic [11:0]    trial;
    logic           trial_ge;
    logic [17:0]    contr;
    logic [31:0]    sum_ext;
    logic           last_slot;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_take = o_out.valid && o_out.ready;

    assign i_in.ready             = (r_state == S_IDLE);
    assign o_out.valid            = r_ovalid;
    assign o_out.data.mix_sample  = r_omix;

    // Store write path
    assign wr_addr_ext = {7'd0, i_in.data.write_address};
    assign wr_en = in_acc && (i_in.data.kind == gbm_pkg::KIND_WRITE)
                   && (wr_addr_ext < 17'(STORE_DEPTH));

    // Current slot and window at the advanced counter
    assign cur_cnt  = r_s_cnt[r_idx];
    assign cur_len  = r_s_len[r_idx];
    assign c_new    = 12'(cur_cnt + {7'd0, r_s_step[r_idx]});
    assign two_c    = {c_new, 1'b0};
    assign len_diff = 11'({1'b0, cur_len} - c_new);
    assign rd_addr_ext = 17'({7'd0, r_s_start[r_idx]} + {5'd0, cur_cnt});
    assign rd_en = (r_state == S_SLOT);

    always_comb begin
        if (two_c < {2'd0, cur_len}) begin
            wn_calc = two_c[11:0];
        end else if (c_new <= {1'b0, cur_len}) begin
            wn_calc = {len_diff, 1'b0};
        end else begin
            wn_calc = 12'd0;
        end
    end

    // Sample magnitude; outside the store reads as zero
    assign smp     = r_inrange ? ram_rdata : 16'd0;
    assign smp_mag = smp[15] ? (~smp + 16'd1) : smp;

    // Shared multiplier: gain * |sample|, then product * window
    assign mul_a = (r_state == S_MUL1) ? {16'd0, r_gain} : r_mul;
    assign mul_b = (r_state == S_MUL1) ? smp_mag : {4'd0, r_wn};
    assign mul_p = 42'(mul_a * mul_b);

    // Restoring divider step
    assign trial    = {r_rem, r_quo[15]};
    assign trial_ge = (trial >= {1'b0, r_len});

    // Signed contribution and clamp
    assign contr   = r_neg ? (~{2'd0, r_quo} + 18'd1) : {2'd0, r_quo};
    assign sum_ext = {{(32-SUM_W){r_sum[SUM_W-1]}}, r_sum};

    assign last_slot = (r_idx == IDX_W'(NUM_SLOTS - 1));

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_next    = r_next;
        n_ovalid  = r_ovalid;
        n_s_cnt   = r_s_cnt;
        n_s_start = r_s_start;
        n_s_len   = r_s_len;
        n_s_step  = r_s_step;
        n_s_gain  = r_s_gain;
        n_sum     = r_sum;
        n_len     = r_len;
        n_gain    = r_gain;
        n_wn      = r_wn;
        n_inrange = r_inrange;
        n_neg     = r_neg;
        n_mul     = r_mul;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_dcnt    = r_dcnt;
        n_omix    = r_omix;

        if (out_take) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in.data.kind == gbm_pkg::KIND_TICK)) begin
                    // restart the round-robin slot before the pass
                    if (i_in.data.trigger) begin
                        n_s_cnt[r_next]   = 12'd0;
                        n_s_start[r_next] = i_in.data.grain_start;
                        n_s_len[r_next]   = i_in.data.grain_length;
                        n_s_step[r_next]  = i_in.data.grain_step;
                        n_s_gain[r_next]  = i_in.data.grain_gain;
                        n_next = (r_next == IDX_W'(NUM_SLOTS - 1)) ? '0
                                 : IDX_W'(r_next + 1'b1);
                    end
                    n_idx   = '0;
                    n_sum   = '0;
                    n_state = S_SLOT;
                end
            end
            S_SLOT: begin
                if (cur_cnt < {1'b0, cur_len}) begin
                    n_s_cnt[r_idx] = c_new;
                    n_len     = cur_len;
                    n_gain    = r_s_gain[r_idx];
                    n_wn      = wn_calc;
                    n_inrange = (rd_addr_ext < 17'(STORE_DEPTH));
                    n_state   = S_MUL1;
                end else if (last_slot) begin
                    n_state = S_DONE;
                end else begin
                    n_idx = IDX_W'(r_idx + 1'b1);
                end
            end
            S_MUL1: begin
                n_mul   = mul_p[31:0];
                n_neg   = smp[15];
                n_state = S_MUL2;
            end
            S_MUL2: begin
                // dividend = product >> 15; its top part is already below length
                n_rem   = mul_p[41:31];
                n_quo   = mul_p[30:15];
                n_dcnt  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem = trial_ge ? 11'(trial - {1'b0, r_len}) : trial[10:0];
                n_quo = {r_quo[14:0], trial_ge};
                if (r_dcnt == DCNT_W'(gbm_pkg::DIV_STEPS - 1)) begin
                    n_state = S_ACC;
                end else begin
                    n_dcnt = DCNT_W'(r_dcnt + 1'b1);
                end
            end
            S_ACC: begin
                n_sum = SUM_W'(r_sum + {{(SUM_W-18){contr[17]}}, contr});
                if (last_slot) begin
                    n_state = S_DONE;
                end else begin
                    n_idx   = IDX_W'(r_idx + 1'b1);
                    n_state = S_SLOT;
                end
            end
            S_DONE: begin
                if (!r_ovalid || o_out.ready) begin
                    priority if ($signed(sum_ext) > gbm_pkg::MIX_MAX) begin
                        n_omix = 20'(gbm_pkg::MIX_MAX);
                    end else if ($signed(sum_ext) < gbm_pkg::MIX_MIN) begin
                        n_omix = 20'(gbm_pkg::MIX_MIN);
                    end else begin
                        n_omix = sum_ext[19:0];
                    end
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and slot bank registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_next   <= '0;
            r_ovalid <= 1'b0;
            for (int s = 0; s < NUM_SLOTS; s++) begin
                r_s_cnt[s]   <= gbm_pkg::SLOT_RESET_COUNT;
                r_s_start[s] <= 10'd0;
                r_s_len[s]   <= gbm_pkg::SLOT_RESET_LEN;
                r_s_step[s]  <= gbm_pkg::SLOT_RESET_STEP;
                r_s_gain[s]  <= gbm_pkg::SLOT_RESET_GAIN;
            end
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_next    <= n_next;
            r_ovalid  <= n_ovalid;
            r_s_cnt   <= n_s_cnt;
            r_s_start <= n_s_start;
            r_s_len   <= n_s_len;
            r_s_step  <= n_s_step;
            r_s_gain  <= n_s_gain;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_sum     <= n_sum;
        r_len     <= n_len;
        r_gain    <= n_gain;
        r_wn      <= n_wn;
        r_inrange <= n_inrange;
        r_neg     <= n_neg;
        r_mul     <= n_mul;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_dcnt    <= n_dcnt;
        r_omix    <= n_omix;
    end

    // Sample store
    gbm_ram #(
        .WIDTH (16),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr_ext[AW-1:0]),
        .i_wdata (i_in.data.write_sample),
        .i_re    (rd_en),
        .i_raddr (rd_addr_ext[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Checks
    `GBM_ASSERT_IMP(a_idx_range, i_clk, i_rst_n, (r_state != S_IDLE), (r_idx <= IDX_W'(NUM_SLOTS - 1)), "slot index out of range")
    `GBM_ASSERT_IMP(a_div_rem, i_clk, i_rst_n, (r_state == S_DIV), (r_rem < r_len), "divider remainder not below length")
    `GBM_ASSERT_NXT(a_tick_busy, i_clk, i_rst_n, (in_acc && (i_in.data.kind == gbm_pkg::KIND_TICK)), (r_state == S_SLOT), "tick word did not start a slot pass")
    `GBM_ASSERT_NXT(a_done_load, i_clk, i_rst_n, ((r_state == S_DONE) && !r_ovalid), (r_ovalid && (r_state == S_IDLE)), "finished mix not loaded")

endmodule

`default_nettype wire

// ----- rtl/gbm_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module gbm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
